/* rtl/assert_macros.svh */
// Assertion macros shared by the point rotate and project RTL.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is high.
`define PRP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

// Clocked check that also holds during reset.
`define PRP_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");

`endif

/* rtl/prp_pkg.sv */
// Package for the point rotate and project block: defaults, register
// indexes, quarter-wave sine table and fixed-point helpers. No dependencies.
`default_nettype none

package prp_pkg;

   localparam int VIEW_WIDTH_DEF = 80;
   localparam int VIEW_DIST_DEF  = 5;
   localparam int ANGLE_BITS_DEF = 12;

   localparam int COORD_W   = 16;
   localparam int ANGLE_W   = 12;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROTATION_ALPHA = 4'd0,
      CSR_ROTATION_BETA  = 4'd1,
      CSR_PIVOT_X        = 4'd2,
      CSR_PIVOT_Y        = 4'd3,
      CSR_PIVOT_Z        = 4'd4,
      CSR_CAMERA_X       = 4'd5,
      CSR_CAMERA_Y       = 4'd6,
      CSR_CAMERA_Z       = 4'd7
   } csr_index_type;

   typedef logic signed [COORD_W-1:0] coord_type;

   // Quarter-wave sine, Q1.14, 33 points.
   function automatic logic [15:0] qsine_lut(input logic [5:0] i);
      logic [15:0] r;
      case (i)
         6'd0:  r = 16'd0;     6'd1:  r = 16'd804;   6'd2:  r = 16'd1606;
         6'd3:  r = 16'd2404;  6'd4:  r = 16'd3196;  6'd5:  r = 16'd3981;
         6'd6:  r = 16'd4756;  6'd7:  r = 16'd5520;  6'd8:  r = 16'd6270;
         6'd9:  r = 16'd7005;  6'd10: r = 16'd7723;  6'd11: r = 16'd8423;
         6'd12: r = 16'd9102;  6'd13: r = 16'd9760;  6'd14: r = 16'd10394;
         6'd15: r = 16'd11003; 6'd16: r = 16'd11585; 6'd17: r = 16'd12140;
         6'd18: r = 16'd12665; 6'd19: r = 16'd13160; 6'd20: r = 16'd13623;
         6'd21: r = 16'd14053; 6'd22: r = 16'd14449; 6'd23: r = 16'd14811;
         6'd24: r = 16'd15137; 6'd25: r = 16'd15426; 6'd26: r = 16'd15679;
         6'd27: r = 16'd15893; 6'd28: r = 16'd16069; 6'd29: r = 16'd16207;
         6'd30: r = 16'd16305; 6'd31: r = 16'd16364;
         default: r = 16'd16384;
      endcase
      return r;
   endfunction

   // Sine of a 16-bit angle, Q1.14, interpolated and truncated.
   function automatic logic signed [15:0] sine16(input logic [15:0] a);
      logic [14:0] p;
      logic [5:0]  idx;
      logic [8:0]  frac;
      logic [15:0] base;
      logic [15:0] d;
      logic [24:0] prod;
      logic [15:0] val;
      p    = a[14] ? (15'h4000 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
      idx  = p[14:9];
      frac = p[8:0];
      base = qsine_lut(idx);
      d    = qsine_lut(6'(idx + 6'd1)) - base;
      prod = 25'(d) * 25'(frac);
      if (idx >= 6'd32) begin
         val = 16'd16384;
      end else begin
         val = base + 16'(prod >> 9);
      end
      return a[15] ? -$signed(val) : $signed(val);
   endfunction

   // Product of two Q1.14 values, rounded half up to Q1.14.
   function automatic logic signed [15:0] coef(input logic signed [15:0] a,
                                               input logic signed [15:0] b);
      logic signed [31:0] pr;
      pr = a * b;
      return 16'((pr + 32'sd8192) >>> 14);
   endfunction

endpackage

`default_nettype wire

/* rtl/prp_rotate.sv */
// Five-stage rotation pipeline: sines, matrix coefficients, products,
// dot-product sums, rounding with pivot and saturation. Uses prp_pkg.
`default_nettype none

module prp_rotate #(
   parameter int ANGLE_BITS = prp_pkg::ANGLE_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire prp_pkg::coord_type      in_x,
   input  wire prp_pkg::coord_type      in_y,
   input  wire prp_pkg::coord_type      in_z,
   input  wire logic [prp_pkg::ANGLE_W-1:0] alpha,
   input  wire logic [prp_pkg::ANGLE_W-1:0] beta,
   input  wire prp_pkg::coord_type      pivot_x,
   input  wire prp_pkg::coord_type      pivot_y,
   input  wire prp_pkg::coord_type      pivot_z,
   output logic                         out_valid,
   output prp_pkg::coord_type           out_x,
   output prp_pkg::coord_type           out_y,
   output prp_pkg::coord_type           out_z
);
   import prp_pkg::*;

   localparam logic [31:0] ANGLE_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);
   localparam int ANGLE_SHIFT = 16 - ANGLE_BITS;

   logic [4:0] vld_ff;

   // stage 1
   logic [15:0] a16, b16;
   logic signed [16:0] u_ff, v_ff, w_ff;
   logic signed [15:0] sa_ff, ca_ff, sb_ff, cb_ff;
   // stage 2
   logic signed [16:0] u2_ff, v2_ff, w2_ff;
   logic signed [15:0] nsa_ff, ca2_ff, nsb_ff, cb2_ff;
   logic signed [15:0] cacb_ff, casb_ff, sacb_ff, sasb_ff;
   // stage 3
   logic signed [32:0] p_ff [8];
   // stage 4
   logic signed [34:0] sx_ff, sy_ff, sz_ff;
   // stage 5
   logic signed [21:0] rx_in, ry_in, rz_in;
   coord_type rx_ff, ry_ff, rz_ff;

   function automatic coord_type sat16(input logic signed [21:0] v);
      coord_type r;
      if (v > 22'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -22'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   always_comb begin
      a16 = 16'((32'(alpha) & ANGLE_MASK) << ANGLE_SHIFT);
      b16 = 16'((32'(beta) & ANGLE_MASK) << ANGLE_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      u_ff  <= 17'(in_x) - 17'(pivot_x);
      v_ff  <= 17'(in_y) - 17'(pivot_y);
      w_ff  <= 17'(in_z) - 17'(pivot_z);
      sa_ff <= sine16(a16);
      ca_ff <= sine16(16'(a16 + 16'h4000));
      sb_ff <= sine16(b16);
      cb_ff <= sine16(16'(b16 + 16'h4000));

      u2_ff   <= u_ff;
      v2_ff   <= v_ff;
      w2_ff   <= w_ff;
      nsa_ff  <= -sa_ff;
      ca2_ff  <= ca_ff;
      nsb_ff  <= -sb_ff;
      cb2_ff  <= cb_ff;
      cacb_ff <= coef(ca_ff, cb_ff);
      casb_ff <= coef(ca_ff, sb_ff);
      sacb_ff <= coef(sa_ff, cb_ff);
      sasb_ff <= coef(sa_ff, sb_ff);

      p_ff[0] <= cacb_ff * u2_ff;
      p_ff[1] <= nsa_ff * v2_ff;
      p_ff[2] <= casb_ff * w2_ff;
      p_ff[3] <= sacb_ff * u2_ff;
      p_ff[4] <= ca2_ff * v2_ff;
      p_ff[5] <= sasb_ff * w2_ff;
      p_ff[6] <= nsb_ff * u2_ff;
      p_ff[7] <= cb2_ff * w2_ff;

      sx_ff <= 35'(p_ff[0]) + 35'(p_ff[1]) + 35'(p_ff[2]);
      sy_ff <= 35'(p_ff[3]) + 35'(p_ff[4]) + 35'(p_ff[5]);
      sz_ff <= 35'(p_ff[6]) + 35'(p_ff[7]);

      rx_ff <= sat16(rx_in);
      ry_ff <= sat16(ry_in);
      rz_ff <= sat16(rz_in);
   end

   // round half up, drop 14 fraction bits, restore pivot
   always_comb begin
      rx_in = 22'((sx_ff + 35'sd8192) >>> 14) + 22'(pivot_x);
      ry_in = 22'((sy_ff + 35'sd8192) >>> 14) + 22'(pivot_y);
      rz_in = 22'((sz_ff + 35'sd8192) >>> 14) + 22'(pivot_z);
   end

   assign out_valid = vld_ff[4];
   assign out_x     = rx_ff;
   assign out_y     = ry_ff;
   assign out_z     = rz_ff;

endmodule

`default_nettype wire

/* rtl/prp_divider.sv */
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// that travels alongside. Uses assert_macros.svh; no package dependency.
`default_nettype none

module prp_divider #(
   parameter int NW = 31,
   parameter int DW = 17,
   parameter int SW = 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   input  wire logic [NW-1:0] in_dividend,
   input  wire logic [DW-1:0] in_divisor,
   input  wire logic [SW-1:0] in_side,
   output logic               out_valid,
   output logic [NW-1:0]      out_quotient,
   output logic [SW-1:0]      out_side
);

   logic [NW-1:0] vld_ff;
   logic [DW-1:0] rem_ff  [NW];
   logic [NW-1:0] dq_ff   [NW];
   logic [DW-1:0] dvs_ff  [NW];
   logic [SW-1:0] side_ff [NW];

   for (genvar k = 0; k < NW; k++) begin : g_stage
      logic          vld_i;
      logic [DW-1:0] rem_i, dvs_i, rem_in;
      logic [NW-1:0] dq_i;
      logic [SW-1:0] side_i;
      logic [DW:0]   trial, diff;
      logic          ge;

      if (k == 0) begin : g_first
         assign vld_i  = in_valid;
         assign rem_i  = '0;
         assign dq_i   = in_dividend;
         assign dvs_i  = in_divisor;
         assign side_i = in_side;
      end else begin : g_next
         assign vld_i  = vld_ff[k-1];
         assign rem_i  = rem_ff[k-1];
         assign dq_i   = dq_ff[k-1];
         assign dvs_i  = dvs_ff[k-1];
         assign side_i = side_ff[k-1];
      end

      always_comb begin
         trial  = {rem_i, dq_i[NW-1]};
         diff   = trial - {1'b0, dvs_i};
         ge     = trial >= {1'b0, dvs_i};
         rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_i;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         dq_ff[k]   <= {dq_i[NW-2:0], ge};
         dvs_ff[k]  <= dvs_i;
         side_ff[k] <= side_i;
      end
   end

   assign out_valid    = vld_ff[NW-1];
   assign out_quotient = dq_ff[NW-1];
   assign out_side     = side_ff[NW-1];

`include "assert_macros.svh"

   `PRP_ASSERT(a_rem_below_divisor, clock, reset, out_valid |-> (rem_ff[NW-1] < dvs_ff[NW-1]))

endmodule

`default_nettype wire

/* rtl/point_rotate_and_project_top.sv */
// Top level of the point rotate and project block: register file, rotation,
// depth and delta stages, two pipelined dividers and output stage.
// Depends on prp_pkg, prp_rotate, prp_divider and assert_macros.svh.
//
// Usage:
//  - Input: drive req_point_x/y/z and raise start; the point transfers at a
//    rising edge where start is high and busy is low. busy is high only
//    through reset and the cycle after, so one point may enter every cycle.
//  - Output: each point yields one result, shown for exactly one cycle with
//    rsp_valid high. Results leave in input order.
//  - Pipeline: 5 rotation stages + 2 projection setup stages + NW divider
//    stages + 1 output stage, NW = clog2(32*VIEW_WIDTH*VIEW_DIST) + 17.
//    With the defaults NW = 31.
//  - Throughput: one point per cycle; the divider spends one stage per
//    quotient bit, which sets the depth.
//  - Configuration: csr_we with csr_index and csr_wdata writes one register
//    per cycle; write only while no point is in flight.
//  - Reset (synchronous) flushes all stages and loads default registers.
//  - The receiver cannot stall; results must be taken when shown.
`default_nettype none

module point_rotate_and_project_top #(
   parameter int VIEW_WIDTH = prp_pkg::VIEW_WIDTH_DEF,
   parameter int VIEW_DIST  = prp_pkg::VIEW_DIST_DEF,
   parameter int ANGLE_BITS = prp_pkg::ANGLE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire prp_pkg::coord_type            req_point_x,
   input  wire prp_pkg::coord_type            req_point_y,
   input  wire prp_pkg::coord_type            req_point_z,
   output logic                               rsp_valid,
   output prp_pkg::coord_type                 rsp_rotated_x,
   output prp_pkg::coord_type                 rsp_rotated_y,
   output prp_pkg::coord_type                 rsp_rotated_z,
   output prp_pkg::coord_type                 rsp_screen_u,
   output prp_pkg::coord_type                 rsp_screen_v,
   output logic                               rsp_behind_camera,
   input  wire logic                          csr_we,
   input  wire logic [prp_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [prp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import prp_pkg::*;

   localparam int K      = 32 * VIEW_WIDTH * VIEW_DIST;
   localparam int NW     = $clog2(K) + 17;
   localparam int DW     = 17;
   localparam int SW     = 3 * COORD_W + 2;
   localparam int OFFSET = 128 * VIEW_WIDTH;
   localparam int LAT    = 5 + 2 + NW + 1;
   localparam logic signed [18:0] DEN_BASE = 19'(VIEW_DIST * 256);

   // registers
   logic      busy_ff;
   logic [ANGLE_W-1:0] alpha_ff, beta_ff;
   coord_type pivx_ff, pivy_ff, pivz_ff, camx_ff, camy_ff, camz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         alpha_ff <= 12'd20;
         beta_ff  <= 12'd13;
         pivx_ff  <= 16'sd5120;
         pivy_ff  <= '0;
         pivz_ff  <= '0;
         camx_ff  <= '0;
         camy_ff  <= '0;
         camz_ff  <= '0;
      end else begin
         busy_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_ROTATION_ALPHA: alpha_ff <= csr_wdata[ANGLE_W-1:0];
               CSR_ROTATION_BETA:  beta_ff  <= csr_wdata[ANGLE_W-1:0];
               CSR_PIVOT_X:        pivx_ff  <= csr_wdata;
               CSR_PIVOT_Y:        pivy_ff  <= csr_wdata;
               CSR_PIVOT_Z:        pivz_ff  <= csr_wdata;
               CSR_CAMERA_X:       camx_ff  <= csr_wdata;
               CSR_CAMERA_Y:       camy_ff  <= csr_wdata;
               CSR_CAMERA_Z:       camz_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign busy = busy_ff;

   logic req_accept;
   assign req_accept = start && !busy_ff;

   // rotation
   logic      rot_valid;
   coord_type rot_x, rot_y, rot_z;

   prp_rotate #(.ANGLE_BITS(ANGLE_BITS)) u_rotate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_x      (req_point_x),
      .in_y      (req_point_y),
      .in_z      (req_point_z),
      .alpha     (alpha_ff),
      .beta      (beta_ff),
      .pivot_x   (pivx_ff),
      .pivot_y   (pivy_ff),
      .pivot_z   (pivz_ff),
      .out_valid (rot_valid),
      .out_x     (rot_x),
      .out_y     (rot_y),
      .out_z     (rot_z)
   );

   // depth and deltas
   logic signed [18:0] den_in;
   logic               vld6_ff, behind6_ff;
   logic [DW-1:0]      den6_ff;
   logic signed [16:0] dy6_ff, dz6_ff;
   coord_type          rx6_ff, ry6_ff, rz6_ff;

   assign den_in = DEN_BASE + 19'(rot_x) - 19'(camx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld6_ff <= 1'b0;
      end else begin
         vld6_ff <= rot_valid;
      end
   end

   always_ff @(posedge clock) begin
      behind6_ff <= (den_in <= 19'sd0);
      // keep the divisor nonzero when the point is behind the camera
      den6_ff    <= (den_in <= 19'sd0) ? DW'(1) : den_in[DW-1:0];
      dy6_ff     <= 17'(rot_y) - 17'(camy_ff);
      dz6_ff     <= 17'(rot_z) - 17'(camz_ff);
      rx6_ff     <= rot_x;
      ry6_ff     <= rot_y;
      rz6_ff     <= rot_z;
   end

   // scaled magnitudes plus half divisor for rounding
   logic [16:0]   abs_u, abs_v;
   logic          vld7_ff;
   logic [NW-1:0] dvd_u7_ff, dvd_v7_ff;
   logic [DW-1:0] den7_ff;
   logic [SW-1:0] side7_ff;
   logic          dz6_neg7_ff;

   always_comb begin
      abs_u = dy6_ff[16] ? 17'(-dy6_ff) : 17'(dy6_ff);
      abs_v = dz6_ff[16] ? 17'(-dz6_ff) : 17'(dz6_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld7_ff <= 1'b0;
      end else begin
         vld7_ff <= vld6_ff;
      end
   end

   always_ff @(posedge clock) begin
      dvd_u7_ff   <= NW'(abs_u) * NW'(K) + NW'(den6_ff >> 1);
      dvd_v7_ff   <= NW'(abs_v) * NW'(K) + NW'(den6_ff >> 1);
      den7_ff     <= den6_ff;
      side7_ff    <= {behind6_ff, dy6_ff[16], rx6_ff, ry6_ff, rz6_ff};
      dz6_neg7_ff <= dz6_ff[16];
   end

   logic          du_valid, dv_valid;
   logic [NW-1:0] qu, qv;
   logic [SW-1:0] side_u;
   logic          neg_v;

   prp_divider #(.NW(NW), .DW(DW), .SW(SW)) u_div_u (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (vld7_ff),
      .in_dividend  (dvd_u7_ff),
      .in_divisor   (den7_ff),
      .in_side      (side7_ff),
      .out_valid    (du_valid),
      .out_quotient (qu),
      .out_side     (side_u)
   );

   prp_divider #(.NW(NW), .DW(DW), .SW(1)) u_div_v (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (vld7_ff),
      .in_dividend  (dvd_v7_ff),
      .in_divisor   (den7_ff),
      .in_side      (dz6_neg7_ff),
      .out_valid    (dv_valid),
      .out_quotient (qv),
      .out_side     (neg_v)
   );

   // sign restore, centering offset, saturation
   function automatic coord_type finish(input logic [NW-1:0] q, input logic neg);
      logic signed [NW+2:0] s;
      coord_type r;
      s = neg ? -$signed({3'b000, q}) : $signed({3'b000, q});
      s = s + (NW+3)'(OFFSET);
      if (s > (NW+3)'(32767)) begin
         r = 16'sh7fff;
      end else if (s < (NW+3)'(-32768)) begin
         r = 16'sh8000;
      end else begin
         r = s[15:0];
      end
      return r;
   endfunction

   logic      out_behind;
   logic      vld_out_ff, behind_ff;
   coord_type rx_ff, ry_ff, rz_ff, su_ff, sv_ff;

   assign out_behind = side_u[SW-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_out_ff <= 1'b0;
      end else begin
         vld_out_ff <= du_valid;
      end
   end

   always_ff @(posedge clock) begin
      behind_ff <= out_behind;
      rx_ff     <= side_u[3*COORD_W-1:2*COORD_W];
      ry_ff     <= side_u[2*COORD_W-1:COORD_W];
      rz_ff     <= side_u[COORD_W-1:0];
      su_ff     <= out_behind ? '0 : finish(qu, side_u[SW-2]);
      sv_ff     <= out_behind ? '0 : finish(qv, neg_v);
   end

   assign rsp_valid         = vld_out_ff;
   assign rsp_rotated_x     = rx_ff;
   assign rsp_rotated_y     = ry_ff;
   assign rsp_rotated_z     = rz_ff;
   assign rsp_screen_u      = su_ff;
   assign rsp_screen_v      = sv_ff;
   assign rsp_behind_camera = behind_ff;

`include "assert_macros.svh"

   `PRP_ASSERT(a_result_has_request, clock, reset, rsp_valid |-> $past(req_accept, LAT))
   `PRP_ASSERT(a_behind_zero_screen, clock, reset, rsp_valid && rsp_behind_camera |-> (rsp_screen_u == 16'sd0 && rsp_screen_v == 16'sd0))
   `PRP_ASSERT(a_dividers_in_step, clock, reset, du_valid == dv_valid)

endmodule

`default_nettype wire
